FILE: design/lrupr_pkg.sv
// shared constants and default record types for the lru page replacement block
package lrupr_pkg;

   localparam int MAX_FRAMES_DFLT = 8;
   localparam int PAGE_BITS_DFLT  = 16;

   localparam int PAGE_W  = 16;
   localparam int FIDX_W  = 3;
   localparam int CFG_W   = 4;
   localparam int FAULT_W = 16;

   localparam logic [CFG_W-1:0]   FIU_RESET = 4'd8;
   localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

   localparam int IDX_DFLT_W = (MAX_FRAMES_DFLT > 1) ? $clog2(MAX_FRAMES_DFLT) : 1;

   typedef struct packed {
      logic                      vld;
      logic [PAGE_BITS_DFLT-1:0] page;
      logic                      hit;
      logic [IDX_DFLT_W-1:0]     hit_idx;
      logic [IDX_DFLT_W-1:0]     hit_rank;
      logic                      emp;
      logic [IDX_DFLT_W-1:0]     emp_idx;
      logic [IDX_DFLT_W-1:0]     best_rank;
      logic [IDX_DFLT_W-1:0]     best_idx;
      logic [PAGE_BITS_DFLT-1:0] best_page;
   } srch_dflt_type;

   typedef struct packed {
      logic                      commit;
      logic [IDX_DFLT_W-1:0]     slot;
      logic                      write;
      logic                      age_all;
      logic [IDX_DFLT_W-1:0]     limit;
      logic [PAGE_BITS_DFLT-1:0] page;
   } upd_dflt_type;

endpackage

FILE: design/lrupr_req_if.sv
// request channel interface: page reference and start flag
interface lrupr_req_if;
   import lrupr_pkg::*;

   logic              valid;
   logic              ready;
   logic [PAGE_W-1:0] page;
   logic              start_new;

   modport source (output valid, output page, output start_new, input ready);
   modport sink   (input valid, input page, input start_new, output ready);
endinterface

FILE: design/lrupr_rsp_if.sv
// response channel interface: fault, frame and eviction result
interface lrupr_rsp_if;
   import lrupr_pkg::*;

   logic               valid;
   logic               ready;
   logic               fault;
   logic [FIDX_W-1:0]  frame_index;
   logic               evicted_valid;
   logic [PAGE_W-1:0]  evicted_page;
   logic [FAULT_W-1:0] fault_total;

   modport source (output valid, output fault, output frame_index, output evicted_valid,
                   output evicted_page, output fault_total, input ready);
   modport sink   (input valid, input fault, input frame_index, input evicted_valid,
                   input evicted_page, input fault_total, output ready);
endinterface

FILE: design/lrupr_cell.sv
// one frame cell: holds page, valid and rank, adds its match to the passing search record
module lrupr_cell #(
   parameter int  MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DFLT,
   parameter int  PAGE_BITS  = lrupr_pkg::PAGE_BITS_DFLT,
   parameter int  INDEX      = 0,
   parameter type srch_type  = lrupr_pkg::srch_dflt_type,
   parameter type upd_type   = lrupr_pkg::upd_dflt_type
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [$clog2(MAX_FRAMES+1)-1:0]       active,
   input  logic                                  clr,
   input  upd_type                               upd,
   input  srch_type                              tok_in,
   output srch_type                              tok_out
);
   import lrupr_pkg::*;

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W = $clog2(MAX_FRAMES+1);
   localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(MAX_FRAMES - 1);
   localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(INDEX);

   logic                 valid_ff, valid_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [IDX_W-1:0]     rank_ff, rank_in;
   srch_type             tok_ff, tok_in_nxt;
   logic                 act;

   assign act = CNT_W'(INDEX) < active;

   // search contribution
   always_comb begin
      tok_in_nxt = tok_in;
      if (act && valid_ff && (page_ff == tok_in.page) && !tok_in.hit) begin
         tok_in_nxt.hit      = 1'b1;
         tok_in_nxt.hit_idx  = MY_IDX;
         tok_in_nxt.hit_rank = rank_ff;
      end
      if (act && !valid_ff && !tok_in.emp) begin
         tok_in_nxt.emp     = 1'b1;
         tok_in_nxt.emp_idx = MY_IDX;
      end
      if (act && ((INDEX == 0) || (rank_ff > tok_in.best_rank))) begin
         tok_in_nxt.best_rank = rank_ff;
         tok_in_nxt.best_idx  = MY_IDX;
         tok_in_nxt.best_page = page_ff;
      end
   end

   // state update
   always_comb begin
      valid_in = valid_ff;
      page_in  = page_ff;
      rank_in  = rank_ff;
      priority if (clr) begin
         valid_in = 1'b0;
         page_in  = '0;
         rank_in  = '0;
      end else if (upd.commit && (upd.slot == MY_IDX)) begin
         rank_in = '0;
         if (upd.write) begin
            valid_in = 1'b1;
            page_in  = upd.page;
         end
      end else if (upd.commit && valid_ff && (upd.age_all || (rank_ff < upd.limit)) &&
                   (rank_ff < RANK_MAX)) begin
         rank_in = rank_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.vld <= 1'b0;
      end else begin
         tok_ff <= tok_in_nxt;
      end
   end

   assign tok_out = tok_ff;

endmodule

FILE: design/lru_page_replacement.sv
// top level: lru page frame table built as a chain of frame cells
// Each request passes through these steps from acceptance until the next request can be
// accepted: the launch register takes the search record, the record walks the chain of frame
// cells gathering hit, empty-frame and oldest-frame matches, a hold register keeps the outcome,
// and in the commit step every cell updates its rank and contents in parallel and the
// response register loads. The response is held until taken; a new request may be accepted
// while it waits, and its commit waits for the response register to free. Configuration
// writes to frames_in_use are taken at any edge with csr_we high.
module lru_page_replacement #(
   parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DFLT,
   parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DFLT
) (
   input  logic                       clock,
   input  logic                       reset,
   lrupr_req_if.sink                  req_chan,
   lrupr_rsp_if.source                rsp_chan,
   input  logic                       csr_we,
   input  logic [lrupr_pkg::CFG_W-1:0] csr_wdata
);
   import lrupr_pkg::*;

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W = $clog2(MAX_FRAMES+1);

   typedef struct packed {
      logic                 vld;
      logic [PAGE_BITS-1:0] page;
      logic                 hit;
      logic [IDX_W-1:0]     hit_idx;
      logic [IDX_W-1:0]     hit_rank;
      logic                 emp;
      logic [IDX_W-1:0]     emp_idx;
      logic [IDX_W-1:0]     best_rank;
      logic [IDX_W-1:0]     best_idx;
      logic [PAGE_BITS-1:0] best_page;
   } srch_type;

   typedef struct packed {
      logic                 commit;
      logic [IDX_W-1:0]     slot;
      logic                 write;
      logic                 age_all;
      logic [IDX_W-1:0]     limit;
      logic [PAGE_BITS-1:0] page;
   } upd_type;

   logic [CFG_W-1:0]   fiu_ff;
   logic [CNT_W-1:0]   active;
   logic               busy_ff;
   logic               req_fire;
   logic               clr;
   srch_type           inj_ff;
   srch_type           tok [MAX_FRAMES+1];
   srch_type           fin_ff;
   logic               commit;
   upd_type            upd;
   logic               fault;
   logic               ev_valid;
   logic [PAGE_BITS-1:0] ev_page;
   logic [FAULT_W-1:0] count_ff, count_in;

   logic               rsp_valid_ff;
   logic               rsp_fault_ff;
   logic [FIDX_W-1:0]  rsp_idx_ff;
   logic               rsp_ev_valid_ff;
   logic [PAGE_W-1:0]  rsp_ev_page_ff;
   logic [FAULT_W-1:0] rsp_total_ff;

   assign req_chan.ready = !busy_ff;
   assign req_fire       = req_chan.valid && !busy_ff;
   assign clr            = req_fire && req_chan.start_new;

   // clamp the frame count
   always_comb begin
      priority if (fiu_ff == '0) begin
         active = CNT_W'(1);
      end else if (int'(fiu_ff) > MAX_FRAMES) begin
         active = CNT_W'(MAX_FRAMES);
      end else begin
         active = CNT_W'(fiu_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff <= FIU_RESET;
      end else if (csr_we) begin
         fiu_ff <= csr_wdata;
      end
   end

   // search record launch
   always_ff @(posedge clock) begin
      if (reset) begin
         inj_ff.vld <= 1'b0;
      end else begin
         inj_ff.vld       <= req_fire;
         inj_ff.page      <= PAGE_BITS'(req_chan.page);
         inj_ff.hit       <= 1'b0;
         inj_ff.hit_idx   <= '0;
         inj_ff.hit_rank  <= '0;
         inj_ff.emp       <= 1'b0;
         inj_ff.emp_idx   <= '0;
         inj_ff.best_rank <= '0;
         inj_ff.best_idx  <= '0;
         inj_ff.best_page <= '0;
      end
   end

   assign tok[0] = inj_ff;

   for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
      lrupr_cell #(
         .MAX_FRAMES (MAX_FRAMES),
         .PAGE_BITS  (PAGE_BITS),
         .INDEX      (i),
         .srch_type  (srch_type),
         .upd_type   (upd_type)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .active  (active),
         .clr     (clr),
         .upd     (upd),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   // hold finished search until the response register is free
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff.vld <= 1'b0;
      end else if (tok[MAX_FRAMES].vld) begin
         fin_ff <= tok[MAX_FRAMES];
      end else if (commit) begin
         fin_ff.vld <= 1'b0;
      end
   end

   assign commit = fin_ff.vld && (!rsp_valid_ff || rsp_chan.ready);

   // replacement decision
   always_comb begin
      upd.commit  = commit;
      upd.page    = fin_ff.page;
      upd.slot    = fin_ff.best_idx;
      upd.write   = 1'b1;
      upd.age_all = 1'b0;
      upd.limit   = fin_ff.best_rank;
      fault       = 1'b1;
      ev_valid    = 1'b0;
      ev_page     = '0;
      priority if (fin_ff.hit) begin
         upd.slot  = fin_ff.hit_idx;
         upd.write = 1'b0;
         upd.limit = fin_ff.hit_rank;
         fault     = 1'b0;
      end else if (fin_ff.emp) begin
         upd.slot    = fin_ff.emp_idx;
         upd.age_all = 1'b1;
      end else begin
         ev_valid = 1'b1;
         ev_page  = fin_ff.best_page;
      end
   end

   assign count_in = (fault && (count_ff != FAULT_MAX)) ? count_ff + 1'b1 : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         priority if (clr) begin
            count_ff <= '0;
         end else if (commit) begin
            count_ff <= count_in;
         end
         priority if (req_fire) begin
            busy_ff <= 1'b1;
         end else if (commit) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_fault_ff    <= fault;
         rsp_idx_ff      <= FIDX_W'(upd.slot);
         rsp_ev_valid_ff <= ev_valid;
         rsp_ev_page_ff  <= PAGE_W'(ev_page);
         rsp_total_ff    <= count_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.fault         = rsp_fault_ff;
   assign rsp_chan.frame_index   = rsp_idx_ff;
   assign rsp_chan.evicted_valid = rsp_ev_valid_ff;
   assign rsp_chan.evicted_page  = rsp_ev_page_ff;
   assign rsp_chan.fault_total   = rsp_total_ff;

endmodule

FILE: tb/sv/tb_lru_page_replacement.sv
// testbench for the lru page frame table: directed and random requests checked by a scoreboard
`timescale 1ns / 100ps

module tb_lru_page_replacement;
   import lrupr_pkg::*;

   localparam int N_FRAMES    = MAX_FRAMES_DFLT;
   localparam int HOLD_CYCLES = 200;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic               fault;
      logic [FIDX_W-1:0]  frame_index;
      logic               evicted_valid;
      logic [PAGE_W-1:0]  evicted_page;
      logic [FAULT_W-1:0] fault_total;
   } frame_result_type;

   class frame_tracker_type;
      logic [PAGE_W-1:0]  page_of [N_FRAMES];
      bit                 held    [N_FRAMES];
      logic [FIDX_W-1:0]  rank_of [N_FRAMES];
      logic [FAULT_W-1:0] faults;
      logic [CFG_W-1:0]   frames_reg;
      frame_result_type   awaited_q[$];
      int                 errors;

      function new();
         clear_table();
         frames_reg = FIU_RESET;
         errors     = 0;
      endfunction

      function void clear_table();
         for (int i = 0; i < N_FRAMES; i++) begin
            page_of[i] = '0;
            held[i]    = 1'b0;
            rank_of[i] = '0;
         end
         faults = '0;
      endfunction

      function void set_frames(logic [CFG_W-1:0] v);
         frames_reg = v;
      endfunction

      function int pending();
         return awaited_q.size();
      endfunction

      // make one frame the most recent, ageing valid frames ranked below the limit
      function void promote(int slot, int limit);
         for (int i = 0; i < N_FRAMES; i++) begin
            if (i != slot && held[i] && rank_of[i] < limit && rank_of[i] < N_FRAMES - 1)
               rank_of[i] = rank_of[i] + 1'b1;
         end
         rank_of[slot] = '0;
      endfunction

      function void note_request(logic [PAGE_W-1:0] pg, logic st);
         frame_result_type r;
         int               active;
         int               slot;
         int               best;
         bit               found;
         r = '0;
         if (st)
            clear_table();
         active = int'(frames_reg);
         if (active < 1)
            active = 1;
         if (active > N_FRAMES)
            active = N_FRAMES;
         found = 1'b0;
         slot  = 0;
         for (int f = 0; f < active; f++) begin
            if (!found && held[f] && page_of[f] == pg) begin
               slot  = f;
               found = 1'b1;
            end
         end
         if (found) begin
            promote(slot, int'(rank_of[slot]));
         end else begin
            r.fault = 1'b1;
            if (faults != FAULT_MAX)
               faults = faults + 1'b1;
            for (int f = 0; f < active; f++) begin
               if (!found && !held[f]) begin
                  slot  = f;
                  found = 1'b1;
               end
            end
            if (found) begin
               held[slot]    = 1'b1;
               page_of[slot] = pg;
               promote(slot, N_FRAMES);
            end else begin
               // oldest active frame, lowest index on a tie
               slot = 0;
               best = int'(rank_of[0]);
               for (int f = 1; f < active; f++) begin
                  if (int'(rank_of[f]) > best) begin
                     best = int'(rank_of[f]);
                     slot = f;
                  end
               end
               r.evicted_valid = 1'b1;
               r.evicted_page  = page_of[slot];
               page_of[slot]   = pg;
               promote(slot, best);
            end
         end
         r.frame_index = FIDX_W'(slot);
         r.fault_total = faults;
         awaited_q.insert(awaited_q.size(), r);
      endfunction

      function void check_response(frame_result_type got);
         frame_result_type want;
         if (awaited_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response: fault=%0d frame=%0d evicted=%0d/%h total=%0d",
                        got.fault, got.frame_index, got.evicted_valid, got.evicted_page,
                        got.fault_total);
            return;
         end
         want = awaited_q.pop_front();
         if (got.fault !== want.fault || got.frame_index !== want.frame_index ||
             got.evicted_valid !== want.evicted_valid ||
             got.evicted_page !== want.evicted_page || got.fault_total !== want.fault_total) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: expected fault=%0d frame=%0d evicted=%0d/%h total=%0d,",
                         " got fault=%0d frame=%0d evicted=%0d/%h total=%0d"},
                        want.fault, want.frame_index, want.evicted_valid, want.evicted_page,
                        want.fault_total, got.fault, got.frame_index, got.evicted_valid,
                        got.evicted_page, got.fault_total);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [CFG_W-1:0]  csr_wdata;
   bit                idle_on;
   bit                hold_rsp;
   bit                hold_taken;
   int                stall_cycles;
   frame_result_type  seen;
   frame_tracker_type sb;

   lrupr_req_if req_bus ();
   lrupr_rsp_if rsp_bus ();

   lru_page_replacement u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // response side: random back-pressure plus one long hold-off on demand
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_bus.ready <= !(idle_on && $urandom_range(0, 99) < 18);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.fault         = rsp_bus.fault;
         seen.frame_index   = rsp_bus.frame_index;
         seen.evicted_valid = rsp_bus.evicted_valid;
         seen.evicted_page  = rsp_bus.evicted_page;
         seen.fault_total   = rsp_bus.fault_total;
         sb.check_response(seen);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_req(input logic [PAGE_W-1:0] pg, input logic st);
      while (idle_on && $urandom_range(0, 99) < 18) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.page      <= pg;
      req_bus.start_new <= st;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(pg, st);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_frames(input logic [CFG_W-1:0] v);
      req_bus.valid <= 1'b0;
      wait_drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_frames(v);
   endtask

   task automatic run_mix(input logic [CFG_W-1:0] frames, input int count, input bit squeeze);
      logic [PAGE_W-1:0] base;
      logic [PAGE_W-1:0] pg;
      int                span;
      write_frames(frames);
      base = PAGE_W'($urandom_range(0, 16'hFFF0));
      span = $urandom_range(2, 12);
      for (int n = 0; n < count; n++) begin
         if (squeeze && n == 30)
            hold_rsp = 1'b1;
         if ($urandom_range(0, 99) < 85)
            pg = base + PAGE_W'($urandom_range(0, span));
         else
            pg = PAGE_W'($urandom_range(0, 16'hFFFF));
         send_req(pg, $urandom_range(0, 99) < 3);
      end
   endtask

   initial begin
      sb                = new();
      idle_on           = 1'b1;
      hold_rsp          = 1'b0;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.page      = '0;
      req_bus.start_new = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: fill, hit, evict, shrunk and out-of-range frame counts, restart
      send_req(16'h0000, 1'b1);
      send_req(16'hFFFF, 1'b0);
      send_req(16'h0000, 1'b0);
      for (int p = 1; p <= 6; p++)
         send_req(PAGE_W'(p), 1'b0);
      send_req(16'hFFFF, 1'b0);
      send_req(16'h8000, 1'b0);
      send_req(16'h5555, 1'b0);
      send_req(16'hAAAA, 1'b0);
      send_req(16'h8000, 1'b0);
      write_frames(4'd1);
      send_req(16'h8000, 1'b0);
      send_req(16'hFFFF, 1'b0);
      send_req(16'h1234, 1'b0);
      write_frames(4'd0);
      send_req(16'h1234, 1'b0);
      send_req(16'h0002, 1'b0);
      write_frames(4'd15);
      send_req(16'hFFFF, 1'b0);
      send_req(16'h1234, 1'b0);
      send_req(16'h0007, 1'b1);
      send_req(16'h0007, 1'b0);
      send_req(16'h7FFF, 1'b0);

      run_mix(4'd3, 100, 1'b0);
      run_mix(4'd1, 100, 1'b0);
      run_mix(4'd8, 100, 1'b1);
      run_mix(4'd0, 100, 1'b0);
      run_mix(4'd15, 100, 1'b0);
      // stretch with no idling on either side
      idle_on = 1'b0;
      run_mix(4'd5, 100, 1'b0);
      idle_on = 1'b1;
      run_mix(4'd2, 100, 1'b0);
      run_mix(4'd9, 100, 1'b0);
      run_mix(CFG_W'($urandom_range(0, 15)), 100, 1'b0);

      req_bus.valid <= 1'b0;
      wait_drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
design/lrupr_pkg.sv
design/lrupr_req_if.sv
design/lrupr_rsp_if.sv
design/lrupr_cell.sv
design/lru_page_replacement.sv
tb/sv/tb_lru_page_replacement.sv
